@@ sv/sks_pkg.sv @@
// Shared types, codes and key compare helpers for the segmented key sorter.
// Depends on nothing; used by sks_cell and segmented_key_sorter_core.
`timescale 1ns / 1ps
`default_nettype none

package sks_pkg;

  localparam int unsigned KeyWidth        = 64;
  localparam int unsigned DefaultCapacity = 64;

  // Configuration register indexes.
  localparam logic CFG_DESCENDING = 1'b0;
  localparam logic CFG_WIDE_KEYS  = 1'b1;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SORT,
    OP_EMIT
  } sks_op_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } sks_state_e;

  typedef struct packed {
    sks_op_e op;
    logic    desc;
    logic    wide;
  } sks_ctrl_t;

  // Low 32 bits, sign-extended.
  function automatic logic [KeyWidth-1:0] narrow_f(input logic [KeyWidth-1:0] k);
    return {{(KeyWidth - 32){k[31]}}, k[31:0]};
  endfunction

  // True when key a must come after key b in the chosen order.
  function automatic logic after_f(input logic [KeyWidth-1:0] a,
                                   input logic [KeyWidth-1:0] b,
                                   input logic desc,
                                   input logic wide);
    logic [KeyWidth-1:0] va;
    logic [KeyWidth-1:0] vb;
    va = wide ? a : narrow_f(a);
    vb = wide ? b : narrow_f(b);
    return desc ? ($signed(va) < $signed(vb)) : ($signed(va) > $signed(vb));
  endfunction

endpackage

`default_nettype wire

@@ sv/sks_cell.sv @@
// One cell of the sorting chain: holds one key, shifts it to a neighbor or
// swaps it with a neighbor. Depends on sks_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sks_cell (
  input  wire logic                         clk_i,
  input  wire sks_pkg::sks_ctrl_t           ctrl_i,
  input  wire logic                         swap_lo_i,
  input  wire logic                         swap_hi_i,
  input  wire logic [sks_pkg::KeyWidth-1:0] left_key_i,
  input  wire logic [sks_pkg::KeyWidth-1:0] right_key_i,
  output logic      [sks_pkg::KeyWidth-1:0] key_o
);

  logic [sks_pkg::KeyWidth-1:0] key_q;
  logic [sks_pkg::KeyWidth-1:0] key_d;

  // The lower cell of a pair keeps the key that comes first, the upper one
  // the key that comes later; both evaluate the same compare.
  always_comb begin
    key_d = key_q;
    unique case (ctrl_i.op)
      sks_pkg::OP_LOAD: key_d = left_key_i;
      sks_pkg::OP_EMIT: key_d = right_key_i;
      sks_pkg::OP_SORT: begin
        if (swap_lo_i && sks_pkg::after_f(key_q, right_key_i, ctrl_i.desc, ctrl_i.wide)) begin
          key_d = right_key_i;
        end else if (swap_hi_i &&
                     sks_pkg::after_f(left_key_i, key_q, ctrl_i.desc, ctrl_i.wide)) begin
          key_d = left_key_i;
        end
      end
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

`default_nettype wire

@@ sv/segmented_key_sorter_core.sv @@
// Top level of the segmented key sorter: control sequencer and chain of cells.
// Depends on sks_pkg and sks_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// -----
// Input beats: a key is taken at a rising edge with start_i high and busy_o
// low. While a segment is open one key can be taken every cycle and shifted into
// the cell chain. Keys beyond SEGMENT_CAPACITY are dropped and the segment is
// marked as overflowed. The beat with segment_end_i high closes the segment.
// After the closing beat busy_o is high. The chain then runs odd-even
// transposition passes, as many as there are kept keys, using the neighbor
// compare in each cell. Then the results leave cell 0, one per
// cycle, each shown for exactly one cycle with result_valid_o high; the last
// one carries last_of_segment_o. busy_o falls in the cycle after the last
// result.
// The receiver cannot stall: every result is taken in the cycle it is shown.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_addr_i
// (descending, wide_keys). Both are latched when a segment closes.
// Reset clears the fill count, the overflow flag, the sequencer and both
// configuration registers; the stored keys are left as they are.
module segmented_key_sorter_core #(
  parameter int unsigned SEGMENT_CAPACITY = sks_pkg::DefaultCapacity
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_addr_i,
  input  wire logic                                cfg_wdata_i,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [sks_pkg::KeyWidth-1:0] key_i,
  input  wire logic                                segment_end_i,
  output logic                                     result_valid_o,
  output logic signed      [sks_pkg::KeyWidth-1:0] sorted_key_o,
  output logic                                     last_of_segment_o,
  output logic                                     overflowed_o
);

  localparam int unsigned Cap = SEGMENT_CAPACITY;
  localparam int unsigned FW  = $clog2(Cap + 1);
  localparam logic [FW-1:0] CapCount = FW'(Cap);

  // Configuration registers and the copy latched at segment close.
  logic cfg_desc_q, cfg_wide_q;
  logic desc_q, desc_d, wide_q, wide_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_desc_q <= 1'b0;
      cfg_wide_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        sks_pkg::CFG_DESCENDING: cfg_desc_q <= cfg_wdata_i;
        sks_pkg::CFG_WIDE_KEYS:  cfg_wide_q <= cfg_wdata_i;
        default:                 cfg_desc_q <= cfg_desc_q;
      endcase
    end
  end

  // Sequencer state. fill_q is the number of occupied cells, counted from
  // cell 0; it also counts down the results still to be emitted.
  sks_pkg::sks_state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] pass_q, pass_d;
  logic          ovf_q, ovf_d;
  logic          accept;
  sks_pkg::sks_ctrl_t ctrl;

  assign accept = start_i && (state_q == sks_pkg::ST_LOAD);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    pass_d    = pass_q;
    ovf_d     = ovf_q;
    desc_d    = desc_q;
    wide_d    = wide_q;
    ctrl.op   = sks_pkg::OP_HOLD;
    ctrl.desc = desc_q;
    ctrl.wide = wide_q;
    unique case (state_q)
      sks_pkg::ST_LOAD: begin
        if (accept) begin
          if (fill_q < CapCount) begin
            ctrl.op = sks_pkg::OP_LOAD;
            fill_d  = fill_q + FW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (segment_end_i) begin
            state_d = sks_pkg::ST_SORT;
            pass_d  = '0;
            desc_d  = cfg_desc_q;
            wide_d  = cfg_wide_q;
          end
        end
      end
      sks_pkg::ST_SORT: begin
        ctrl.op = sks_pkg::OP_SORT;
        pass_d  = pass_q + FW'(1);
        // n passes put n keys in order.
        if ({1'b0, pass_q} + (FW + 1)'(1) >= {1'b0, fill_q}) begin
          state_d = sks_pkg::ST_EMIT;
        end
      end
      sks_pkg::ST_EMIT: begin
        ctrl.op = sks_pkg::OP_EMIT;
        fill_d  = fill_q - FW'(1);
        if (fill_q == FW'(1)) begin
          state_d = sks_pkg::ST_LOAD;
          ovf_d   = 1'b0;
        end
      end
      default: state_d = sks_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sks_pkg::ST_LOAD;
      fill_q  <= '0;
      pass_q  <= '0;
      ovf_q   <= 1'b0;
      desc_q  <= 1'b0;
      wide_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pass_q  <= pass_d;
      ovf_q   <= ovf_d;
      desc_q  <= desc_d;
      wide_q  <= wide_d;
    end
  end

  // Chain of cells. Cell 0 takes new keys and hands out results. In a sort
  // pass, pairs start at even cells on even passes and at odd cells on odd
  // passes; a pair only compares when both of its cells are occupied.
  logic [sks_pkg::KeyWidth-1:0] cell_key [Cap];

  for (genvar i = 0; i < Cap; i++) begin : g_cell
    localparam logic          Odd  = (i % 2) == 1;
    localparam logic [FW:0]   Idx  = (FW + 1)'(i);
    logic [sks_pkg::KeyWidth-1:0] left_key, right_key;
    logic swap_lo, swap_hi;

    if (i == 0) begin : g_first
      assign left_key = key_i;
      assign swap_hi  = 1'b0;
    end else begin : g_inner_left
      assign left_key = cell_key[i-1];
      assign swap_hi  = (state_q == sks_pkg::ST_SORT) && (pass_q[0] != Odd) &&
                        (Idx < {1'b0, fill_q});
    end

    if (i == Cap - 1) begin : g_last
      assign right_key = '0;
      assign swap_lo   = 1'b0;
    end else begin : g_inner_right
      assign right_key = cell_key[i+1];
      assign swap_lo   = (state_q == sks_pkg::ST_SORT) && (pass_q[0] == Odd) &&
                         (Idx + (FW + 1)'(1) < {1'b0, fill_q});
    end

    sks_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .swap_lo_i   (swap_lo),
      .swap_hi_i   (swap_hi),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .key_o       (cell_key[i])
    );
  end

  // Results come straight from cell 0 while emitting.
  assign busy_o            = (state_q != sks_pkg::ST_LOAD);
  assign result_valid_o    = (state_q == sks_pkg::ST_EMIT);
  assign sorted_key_o      = wide_q ? cell_key[0] : sks_pkg::narrow_f(cell_key[0]);
  assign last_of_segment_o = (fill_q == FW'(1));
  assign overflowed_o      = ovf_q;

  // The occupancy never exceeds the chain length.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CapCount)
    else $error("fill count beyond capacity");

  // Sorting and emitting only happen with at least one key held.
  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (fill_q != '0))
    else $error("busy with an empty chain");

  // Results of a segment come in an unbroken run.
  a_emit_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_segment_o) |=> result_valid_o)
    else $error("gap inside a segment's results");

  // After the final result the block is ready for keys again.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_segment_o) |=> (!busy_o && (fill_q == '0) && !ovf_q))
    else $error("block not released after final result");

endmodule

`default_nettype wire
